>>> design/dfr_pkg.sv
package dfr_pkg;

  // request codes
  localparam logic [1:0] REQ_ARM  = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // result event codes
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_BYTE  = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SEQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FULL = 3'd5;

  localparam int unsigned CFG_DATA_W = 64;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] data;
    logic [8:0] position;
    logic       last;
    logic       timed_out;
    logic       overflow;
  } out_item_t;

endpackage

>>> design/delimited_frame_receiver.sv
// Delimited frame receiver. An arm transaction starts a frame search: received bytes are
// matched against the start delimiter (the newest start_len bytes); the bytes after it are
// emitted with frame positions that count the start bytes, until the newest stop_len bytes
// equal the stop delimiter, a timeout of tick transactions expires, or MAX_FRAME bytes have
// been taken. One input transaction is accepted every clock cycle while input ready is high;
// the work is a single pass of logic (byte window shift plus two window compares of at most
// MAX_DELIM bytes) into the state and result registers, so a result is registered into the
// output register, or into the skid entry while an older result blocks it. A two-entry output
// buffer lets one more input transaction in while a result is stalled; input ready drops
// only when both entries hold results. Configuration writes take effect on the next cycle.
module delimited_frame_receiver #(
  parameter int unsigned MAX_FRAME = 256,
  parameter int unsigned MAX_DELIM = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dfr_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [dfr_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  dfr_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output dfr_pkg::out_item_t                   out_data_o
);
  import dfr_pkg::*;

  localparam int unsigned WIN_W  = 8 * MAX_DELIM;
  localparam int unsigned FILL_W = $clog2(MAX_DELIM + 1);
  localparam int unsigned FC_W   = $clog2(MAX_FRAME + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEEK,
    PH_COLLECT
  } phase_e;

  // configuration
  logic [3:0]  start_len_q;
  logic [63:0] start_seq_q;
  logic [3:0]  stop_len_q;
  logic [63:0] stop_seq_q;
  logic [31:0] timeout_ticks_q;
  logic        wait_full_q;

  // frame state
  phase_e            phase_q, phase_d;
  logic [WIN_W-1:0]  window_q, window_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FC_W-1:0]   frame_count_q, frame_count_d;
  logic [31:0]       tick_count_q, tick_count_d;

  // output buffer
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  logic      res_valid;
  out_item_t res;

  logic              accept;
  logic [FILL_W-1:0] start_eff, stop_eff, fill_inc;
  logic [WIN_W-1:0]  win_shift;
  logic [31:0]       tick_inc;
  logic              stop_active, stop_immediate;
  logic              start_hit, stop_hit_seek, stop_hit_coll, cap;

  // newest len bytes of the window, oldest first, against the delimiter
  function automatic logic win_match(input logic [WIN_W-1:0] win,
                                     input logic [FILL_W-1:0] fill,
                                     input logic [FILL_W-1:0] len,
                                     input logic [63:0] seq);
    logic [WIN_W-1:0] recent;
    logic [WIN_W-1:0] want;
    recent = win >> (8 * (MAX_DELIM - int'(len)));
    want   = '0;
    for (int k = 0; k < MAX_DELIM; k++) begin
      if (k < int'(len)) begin
        want[8*k +: 8] = seq[8*k +: 8];
      end
    end
    return (len != '0) && (fill >= len) && (recent == want);
  endfunction

  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign start_eff = (start_len_q > 4'(MAX_DELIM)) ? FILL_W'(MAX_DELIM)
                                                   : FILL_W'(start_len_q);
  assign stop_eff  = (stop_len_q > 4'(MAX_DELIM)) ? FILL_W'(MAX_DELIM)
                                                  : FILL_W'(stop_len_q);
  assign stop_active    = !wait_full_q && (stop_eff != '0);
  assign stop_immediate = !wait_full_q && (stop_eff == '0);

  assign win_shift = (window_q >> 8) | (WIN_W'(in_data_i.rx_byte) << (WIN_W - 8));
  assign fill_inc  = (fill_q < FILL_W'(MAX_DELIM)) ? fill_q + 1'b1 : fill_q;
  assign tick_inc  = (tick_count_q != '1) ? tick_count_q + 32'd1 : tick_count_q;

  assign start_hit     = win_match(win_shift, fill_inc, start_eff, start_seq_q);
  // after a start match the fill drops to the start length
  assign stop_hit_seek = stop_active && win_match(win_shift, start_eff, stop_eff, stop_seq_q);
  assign stop_hit_coll = stop_active && win_match(win_shift, fill_inc, stop_eff, stop_seq_q);
  assign cap           = frame_count_q >= FC_W'(MAX_FRAME - 1);

  always_comb begin
    phase_d       = phase_q;
    window_d      = window_q;
    fill_d        = fill_q;
    frame_count_d = frame_count_q;
    tick_count_d  = tick_count_q;
    res_valid     = 1'b0;
    res           = '0;
    if (accept) begin
      unique case (in_data_i.req_type)
        REQ_ARM: begin
          window_d      = '0;
          fill_d        = '0;
          frame_count_d = '0;
          tick_count_d  = '0;
          if (start_eff != '0) begin
            phase_d = PH_SEEK;
          end else if (stop_immediate) begin
            phase_d       = PH_IDLE;
            res_valid     = 1'b1;
            res.event_res = EV_END;
            res.last      = 1'b1;
          end else begin
            phase_d = PH_COLLECT;
          end
        end
        REQ_BYTE: begin
          if (phase_q != PH_IDLE) begin
            window_d = win_shift;
            fill_d   = fill_inc;
            if (phase_q == PH_SEEK) begin
              if (start_hit) begin
                fill_d        = start_eff;
                frame_count_d = FC_W'(start_eff);
                phase_d       = (stop_immediate || stop_hit_seek) ? PH_IDLE : PH_COLLECT;
                res_valid     = 1'b1;
                res.event_res = EV_START;
                res.position  = 9'(start_eff);
                res.last      = stop_immediate || stop_hit_seek;
              end
            end else begin
              frame_count_d = frame_count_q + 1'b1;
              if (stop_hit_coll || cap) begin
                phase_d = PH_IDLE;
              end
              res_valid     = 1'b1;
              res.event_res = EV_BYTE;
              res.data      = in_data_i.rx_byte;
              res.position  = 9'(frame_count_q);
              res.last      = stop_hit_coll || cap;
              res.overflow  = cap && !stop_hit_coll;
            end
          end
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE && timeout_ticks_q != '0) begin
            tick_count_d = tick_inc;
            if (tick_inc >= timeout_ticks_q) begin
              phase_d       = PH_IDLE;
              res_valid     = 1'b1;
              res.event_res = EV_END;
              res.position  = 9'(frame_count_q);
              res.last      = 1'b1;
              res.timed_out = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_len_q     <= '0;
      start_seq_q     <= '0;
      stop_len_q      <= '0;
      stop_seq_q      <= '0;
      timeout_ticks_q <= '0;
      wait_full_q     <= 1'b0;
      phase_q         <= PH_IDLE;
      window_q        <= '0;
      fill_q          <= '0;
      frame_count_q   <= '0;
      tick_count_q    <= '0;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
      out_q           <= '0;
      skid_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_START_LEN: start_len_q     <= cfg_wdata_i[3:0];
          CFG_START_SEQ: start_seq_q     <= cfg_wdata_i;
          CFG_STOP_LEN:  stop_len_q      <= cfg_wdata_i[3:0];
          CFG_STOP_SEQ:  stop_seq_q      <= cfg_wdata_i;
          CFG_TIMEOUT:   timeout_ticks_q <= cfg_wdata_i[31:0];
          CFG_WAIT_FULL: wait_full_q     <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      phase_q       <= phase_d;
      window_q      <= window_d;
      fill_q        <= fill_d;
      frame_count_q <= frame_count_d;
      tick_count_q  <= tick_count_d;
      // output register refills from the skid entry first
      if (!out_valid_q || out_ready_i) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= res_valid;
          skid_q       <= res;
        end else begin
          out_q       <= res;
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_frame_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COLLECT) |-> (frame_count_q < FC_W'(MAX_FRAME)))
    else $error("frame count beyond cap while collecting");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_DELIM))
    else $error("window fill beyond delimiter size");

  a_overflow_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.overflow) |-> (out_q.last && out_q.event_res == EV_BYTE))
    else $error("overflow flag on a result that does not close the frame");

  a_close_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.last) |=> (phase_q == PH_IDLE))
    else $error("frame closed but receiver still active");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import dfr_pkg::*;

  localparam int unsigned FRAME_CAP = 256;
  localparam int unsigned DELIM_MAX = 8;
  localparam int unsigned RX_HOLD_CYCLES = 80;

  // request code with no meaning, the block must ignore it
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // register indexes past the last register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    RX_IDLE    = 2'd0,
    RX_SEEK    = 2'd1,
    RX_COLLECT = 2'd2
  } rx_phase_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  // local copy of the configuration
  logic [3:0]  m_start_len;
  logic [63:0] m_start_seq;
  logic [3:0]  m_stop_len;
  logic [63:0] m_stop_seq;
  logic [31:0] m_timeout;
  logic        m_wait_full;

  // local copy of the receiver state
  rx_phase_e   m_phase;
  logic [63:0] m_window;
  logic [3:0]  m_fill;
  logic [8:0]  m_count;
  logic [31:0] m_ticks;

  out_item_t   pending_events[$];
  out_item_t   want;
  int          fail_count;
  int          live_items;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;

  delimited_frame_receiver u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clip_len(logic [3:0] len);
    return (len > DELIM_MAX) ? DELIM_MAX : int'(len);
  endfunction

  // newest len bytes of the window, oldest first, against the delimiter
  function automatic bit window_hit(int unsigned len, logic [63:0] seq);
    logic [63:0] recent;
    logic [63:0] mask;
    if (len == 0 || len > DELIM_MAX || m_fill < len) return 1'b0;
    recent = m_window >> (64 - 8 * len);
    mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    return recent == (seq & mask);
  endfunction

  function automatic bit stop_armed();
    return !m_wait_full && clip_len(m_stop_len) != 0;
  endfunction

  function automatic bit stop_now();
    return !m_wait_full && clip_len(m_stop_len) == 0;
  endfunction

  function automatic bit is_live(in_item_t it);
    case (it.req_type)
      REQ_ARM:  return 1'b1;
      REQ_BYTE: return m_phase != RX_IDLE;
      REQ_TICK: return m_phase != RX_IDLE && m_timeout != 0;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit predict_frame_event(input in_item_t it, output out_item_t ev);
    int unsigned sl;
    logic [8:0]  pos;
    bit          hit;
    bit          cap;
    bit          done;
    ev = '0;
    case (it.req_type)
      REQ_ARM: begin
        m_window = '0;
        m_fill = '0;
        m_count = '0;
        m_ticks = '0;
        if (clip_len(m_start_len) != 0) begin
          m_phase = RX_SEEK;
          return 1'b0;
        end
        if (stop_now()) begin
          m_phase = RX_IDLE;
          ev.event_res = EV_END;
          ev.last = 1'b1;
          return 1'b1;
        end
        m_phase = RX_COLLECT;
        return 1'b0;
      end
      REQ_BYTE: begin
        if (m_phase == RX_IDLE) return 1'b0;
        m_window = {it.rx_byte, m_window[63:8]};
        if (m_fill < DELIM_MAX) m_fill = m_fill + 4'd1;
        if (m_phase == RX_SEEK) begin
          sl = clip_len(m_start_len);
          if (!window_hit(sl, m_start_seq)) return 1'b0;
          m_fill = 4'(sl);
          m_count = 9'(sl);
          // the stop check may already close the frame on the start bytes
          done = stop_now() || (stop_armed() && window_hit(clip_len(m_stop_len), m_stop_seq));
          m_phase = done ? RX_IDLE : RX_COLLECT;
          ev.event_res = EV_START;
          ev.position = m_count;
          ev.last = done;
          return 1'b1;
        end
        pos = m_count;
        hit = stop_armed() && window_hit(clip_len(m_stop_len), m_stop_seq);
        cap = (int'(pos) + 1 >= FRAME_CAP);
        m_count = pos + 9'd1;
        if (hit || cap) m_phase = RX_IDLE;
        ev.event_res = EV_BYTE;
        ev.data = it.rx_byte;
        ev.position = pos;
        ev.last = hit || cap;
        ev.overflow = cap && !hit;
        return 1'b1;
      end
      REQ_TICK: begin
        if (m_phase == RX_IDLE || m_timeout == 0) return 1'b0;
        if (m_ticks != '1) m_ticks = m_ticks + 32'd1;
        if (m_ticks < m_timeout) return 1'b0;
        m_phase = RX_IDLE;
        ev.event_res = EV_END;
        ev.position = m_count;
        ev.last = 1'b1;
        ev.timed_out = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: event_res %0d position %0d",
               out_data.event_res, out_data.position);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", want.event_res, out_data.event_res);
        check_field("data", want.data, out_data.data);
        check_field("position", want.position, out_data.position);
        check_field("last", want.last, out_data.last);
        check_field("timed_out", want.timed_out, out_data.timed_out);
        check_field("overflow", want.overflow, out_data.overflow);
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    int hold_n;
    out_ready = 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready = 1'b0;
        for (hold_n = 0; hold_n < RX_HOLD_CYCLES; hold_n++) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall = pick_gap(rx_idle_en);
      end
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [7:0] b);
    in_item_t  it;
    out_item_t ev;
    int        gap;
    it.req_type = req;
    it.rx_byte = b;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    if (is_live(it)) live_items++;
    if (predict_frame_event(it, ev)) pending_events.push_back(ev);
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid, let every result drain, then give in-flight no-result items time to retire
  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_START_LEN: m_start_len = value[3:0];
      CFG_START_SEQ: m_start_seq = value;
      CFG_STOP_LEN:  m_stop_len = value[3:0];
      CFG_STOP_SEQ:  m_stop_seq = value;
      CFG_TIMEOUT:   m_timeout = value[31:0];
      CFG_WAIT_FULL: m_wait_full = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] sl, input logic [63:0] ss, input logic [3:0] tl,
                           input logic [63:0] ts, input logic [31:0] to, input logic wf);
    settle_idle();
    cfg_write(CFG_START_LEN, 64'(sl));
    cfg_write(CFG_START_SEQ, ss);
    cfg_write(CFG_STOP_LEN, 64'(tl));
    cfg_write(CFG_STOP_SEQ, ts);
    cfg_write(CFG_TIMEOUT, 64'(to));
    cfg_write(CFG_WAIT_FULL, 64'(wf));
  endtask

  // delimiter bytes in order, now and then a tick in between or a byte dropped
  task automatic send_delim(input logic [63:0] seq, input int unsigned len, input bit broken);
    int unsigned skip;
    skip = broken ? $urandom_range(0, len - 1) : len;
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 8) send_item(REQ_TICK, 8'($urandom));
      if (k != skip) send_item(REQ_BYTE, m_start_seq == seq ? seq[8*k +: 8] : seq[8*k +: 8]);
    end
  endtask

  // payload or noise byte, biased toward delimiter bytes, with stray ticks, unused requests and arms
  task automatic send_mixed();
    int          r;
    logic [63:0] pool;
    r = $urandom_range(0, 99);
    pool = $urandom_range(0, 1) ? m_start_seq : m_stop_seq;
    if (r < 6)       send_item(REQ_TICK, 8'($urandom));
    else if (r < 8)  send_item(REQ_UNUSED, 8'($urandom));
    else if (r < 10) send_item(REQ_ARM, 8'($urandom));
    else if (r < 45) send_item(REQ_BYTE, pool[8*$urandom_range(0, 7) +: 8]);
    else             send_item(REQ_BYTE, 8'($urandom));
  endtask

  task automatic random_frame();
    int n;
    send_item(REQ_ARM, 8'($urandom));
    n = $urandom_range(0, 5);
    repeat (n) send_mixed();
    if ($urandom_range(0, 9) < 8)
      send_delim(m_start_seq, clip_len(m_start_len), $urandom_range(0, 9) == 0);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 10);
    repeat (n) send_mixed();
    if ($urandom_range(0, 9) < 8)
      send_delim(m_stop_seq, clip_len(m_stop_len), $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 9) < 3) begin
      n = $urandom_range(1, 25);
      repeat (n) send_item(REQ_TICK, 8'($urandom));
    end
  endtask

  task automatic random_phase(input logic [3:0] sl, input logic [63:0] ss, input logic [3:0] tl,
                              input logic [63:0] ts, input logic [31:0] to, input logic wf,
                              input int target);
    int first;
    configure(sl, ss, tl, ts, to, wf);
    first = live_items;
    tx_idle_en = $urandom_range(0, 3) != 0;
    rx_idle_en = $urandom_range(0, 3) != 0;
    while (live_items - first < target) random_frame();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // reset values: no delimiters, so an arm closes an empty frame at once
  task automatic test_reset_defaults();
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_UNUSED, 8'hFF);
  endtask

  task automatic test_start_stop();
    // start 7e 81, stop 0d 0a; upper bits of the start word must be masked off
    configure(4'd2, 64'hFFFF_FFFF_FFFF_817E, 4'd2, 64'h0000_0000_0000_0A0D, 32'd0, 1'b0);
    send_item(REQ_ARM, 8'hFF);
    send_item(REQ_BYTE, 8'h7E);
    send_item(REQ_BYTE, 8'h7E);
    send_item(REQ_BYTE, 8'h81);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_BYTE, 8'h0D);
    send_item(REQ_BYTE, 8'h0A);
    send_item(REQ_BYTE, 8'h55);
  endtask

  task automatic test_stop_inside_start();
    configure(4'd3, 64'h0000_0000_0003_0201, 4'd1, 64'h0000_0000_0000_0003, 32'd0, 1'b0);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'h01);
    send_item(REQ_BYTE, 8'h02);
    send_item(REQ_BYTE, 8'h03);
    // stop not inside start: the length check fails at the match
    configure(4'd1, 64'h0000_0000_0000_00C3, 4'd2, 64'h0000_0000_0000_C3C3, 32'd0, 1'b0);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'hC3);
    send_item(REQ_BYTE, 8'hC3);
  endtask

  task automatic test_long_delims();
    // lengths above eight act as eight
    configure(4'd15, 64'hFEDC_BA98_7654_3210, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
              32'hFFFF_FFFF, 1'b0);
    send_item(REQ_ARM, 8'h00);
    for (int k = 0; k < 8; k++) send_item(REQ_BYTE, m_start_seq[8*k +: 8]);
    send_item(REQ_TICK, 8'h00);
    repeat (8) send_item(REQ_BYTE, 8'hFF);
  endtask

  task automatic test_empty_delims();
    configure(4'd0, 64'h0, 4'd1, 64'h0, 32'd0, 1'b0);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'h55);
    send_item(REQ_BYTE, 8'h00);
    // empty stop closes the frame at the start match
    configure(4'd1, 64'h0000_0000_0000_00A5, 4'd0, 64'h0, 32'd0, 1'b0);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'h11);
    send_item(REQ_BYTE, 8'hA5);
  endtask

  task automatic test_timeout();
    configure(4'd2, 64'h0000_0000_0000_BEEF, 4'd1, 64'h0, 32'd3, 1'b0);
    // expires while still seeking
    send_item(REQ_ARM, 8'h00);
    repeat (3) send_item(REQ_TICK, 8'h00);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'hEF);
    send_item(REQ_BYTE, 8'hBE);
    send_item(REQ_BYTE, 8'h44);
    repeat (3) send_item(REQ_TICK, 8'h00);
    // wait-full mode ignores the stop byte
    configure(4'd0, 64'h0, 4'd1, 64'h0000_0000_0000_0044, 32'd2, 1'b1);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'h44);
    repeat (2) send_item(REQ_TICK, 8'h00);
  endtask

  task automatic test_frame_cap();
    logic [7:0] b;
    // stop byte lands exactly on the last allowed position: no overflow flag
    configure(4'd0, 64'h0, 4'd1, 64'h0000_0000_0000_005A, 32'd0, 1'b0);
    send_item(REQ_ARM, 8'h00);
    for (int k = 0; k < FRAME_CAP - 1; k++) begin
      b = 8'($urandom);
      if (b == 8'h5A) b = 8'hA5;
      send_item(REQ_BYTE, b);
    end
    send_item(REQ_BYTE, 8'h5A);
  endtask

  task automatic test_arm_restart();
    configure(4'd1, 64'h0000_0000_0000_0033, 4'd1, 64'h0000_0000_0000_0044, 32'd0, 1'b0);
    cfg_write(CFG_SPARE_LO, '1);
    cfg_write(CFG_SPARE_HI, '1);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'h33);
    send_item(REQ_BYTE, 8'h10);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, 8'h10);
    send_item(REQ_BYTE, 8'h33);
    send_item(REQ_BYTE, 8'h44);
  endtask

  // receiver holds off while every byte makes a result, so the input must stall;
  // nothing but the frame cap ends this frame
  task automatic test_backpressure();
    configure(4'd0, 64'h0, 4'd0, 64'h0, 32'd0, 1'b1);
    tx_idle_en = 1'b0;
    rx_hold_req = 1'b1;
    send_item(REQ_ARM, 8'h00);
    repeat (FRAME_CAP + 1) send_item(REQ_BYTE, 8'($urandom));
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random();
    logic [63:0] s;
    s = {$urandom, $urandom};
    random_phase(4'd2, {$urandom, $urandom}, 4'd2, {$urandom, $urandom}, 32'd0, 1'b0, 6);
    random_phase(4'd8, {$urandom, $urandom}, 4'd8, {$urandom, $urandom},
                 32'hFFFF_FFFF, 1'b0, 6);
    random_phase(4'd1, {$urandom, $urandom}, 4'd3, {$urandom, $urandom}, 32'd20, 1'b0, 6);
    random_phase(4'd0, 64'h0, 4'd1, {$urandom, $urandom}, 32'd0, 1'b0, 6);
    random_phase(4'd3, {$urandom, $urandom}, 4'd0, 64'h0, 32'd5, 1'b1, 6);
    random_phase(4'd15, {$urandom, $urandom}, 4'd12, {$urandom, $urandom}, 32'd1, 1'b0, 6);
    random_phase(4'd2, s, 4'd2, s, 32'($urandom_range(10, 40)), 1'b0, 6);
  endtask

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    m_start_len = '0;
    m_start_seq = '0;
    m_stop_len = '0;
    m_stop_seq = '0;
    m_timeout = '0;
    m_wait_full = 1'b0;
    m_phase = RX_IDLE;
    m_window = '0;
    m_fill = '0;
    m_count = '0;
    m_ticks = '0;
    fail_count = 0;
    live_items = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold_req = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_start_stop();
    test_stop_inside_start();
    test_long_delims();
    test_empty_delims();
    test_timeout();
    test_arm_restart();
    test_backpressure();
    test_frame_cap();
    test_random();

    settle_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
